/* rtl/kvrlp_pkg.sv */
`default_nettype none

package kvrlp_pkg;

  typedef enum logic [3:0] {
    PH_TYPE       = 4'd0,
    PH_KEY_NAME   = 4'd1,
    PH_KEY_VAL    = 4'd2,
    PH_VALUE_NAME = 4'd3,
    PH_VALUE_VAL  = 4'd4,
    PH_TTL_NAME   = 4'd5,
    PH_TTL_VAL    = 4'd6,
    PH_TAIL       = 4'd7,
    PH_DEAD       = 4'd8
  } phase_e;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_KEY    = 2'd1;
  localparam logic [1:0] KIND_VALUE  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] REQ_GET  = 2'd0;
  localparam logic [1:0] REQ_PUT  = 2'd1;
  localparam logic [1:0] REQ_EXIT = 2'd2;

  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_NAME   = 3'd1;
  localparam logic [2:0] ERR_DELIM  = 3'd2;
  localparam logic [2:0] ERR_TYPE   = 3'd3;
  localparam logic [2:0] ERR_EXTRA  = 3'd4;
  localparam logic [2:0] ERR_TTL    = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h80;
  localparam logic [7:0] CH_FF    = 8'hFF;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  localparam logic [2:0] TYPE_LEN_MAX = 3'd7;
  localparam logic [30:0] TTL_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  name_pos;
    logic [2:0]  type_match;
    logic [2:0]  type_len;
    logic [1:0]  kind_seen;
    logic [2:0]  error_seen;
    logic [30:0] ttl_acc;
    logic        ttl_bad;
  } parse_state_t;

  localparam parse_state_t ST_RESET = '{
    phase:      PH_TYPE,
    name_pos:   3'd0,
    type_match: 3'b111,
    type_len:   3'd0,
    kind_seen:  REQ_GET,
    error_seen: ERR_OK,
    ttl_acc:    31'd0,
    ttl_bad:    1'b0
  };

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [1:0]  req_type;
    logic [2:0]  err_code;
    logic [30:0] ttl_value;
    logic        close_session;
  } result_t;

  function automatic logic [2:0] type_length(input logic [1:0] req);
    logic [2:0] len;
    len = 3'd3;
    if (req == REQ_EXIT) len = 3'd4;
    return len;
  endfunction

  function automatic logic [7:0] type_char(input logic [1:0] req, input logic [1:0] pos);
    logic [7:0] c;
    unique case ({req, pos})
      {REQ_GET, 2'd0}:  c = "G";
      {REQ_GET, 2'd1}:  c = "E";
      {REQ_GET, 2'd2}:  c = "T";
      {REQ_PUT, 2'd0}:  c = "P";
      {REQ_PUT, 2'd1}:  c = "U";
      {REQ_PUT, 2'd2}:  c = "T";
      {REQ_EXIT, 2'd0}: c = "E";
      {REQ_EXIT, 2'd1}: c = "X";
      {REQ_EXIT, 2'd2}: c = "I";
      {REQ_EXIT, 2'd3}: c = "T";
      default:          c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] name_length(input phase_e ph);
    logic [2:0] len;
    len = 3'd3;
    if (ph == PH_VALUE_NAME) len = 3'd5;
    return len;
  endfunction

  function automatic logic [7:0] name_char(input phase_e ph, input logic [2:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    unique case (ph)
      PH_KEY_NAME: begin
        unique case (pos)
          3'd0:    c = "K";
          3'd1:    c = "E";
          3'd2:    c = "Y";
          default: c = CH_NUL;
        endcase
      end
      PH_VALUE_NAME: begin
        unique case (pos)
          3'd0:    c = "V";
          3'd1:    c = "A";
          3'd2:    c = "L";
          3'd3:    c = "U";
          3'd4:    c = "E";
          default: c = CH_NUL;
        endcase
      end
      PH_TTL_NAME: begin
        unique case (pos)
          3'd0:    c = "T";
          3'd1:    c = "T";
          3'd2:    c = "L";
          default: c = CH_NUL;
        endcase
      end
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/kv_request_line_parser.sv */
// Request line parser for a key/value cache, fed one byte per word.
// Input channel: ch_i carries a request byte, is_end_i marks the end of the
// request (a zero byte in ch_i ends it as well). Every accepted input word
// yields exactly one output word: nothing, a key byte, a value byte, or the
// final status (type, error code, TTL, close flag) on the end word.
// Each output word is registered in the main or the skid register. Throughput:
// one word per cycle while in_stall_o is low; the parse state and the
// multiply-by-ten TTL accumulator update in the same cycle a byte is taken.
// The output side has a main register and a skid register, so a word is
// accepted while a finished one still waits; in_stall_o rises only when the
// skid register is occupied, i.e. after the receiver held out_stall_i high
// while another word arrived. A stalled output word holds its value.
// Reset clears the valid flags of both output registers and returns the parser to
// the start of a type token; the end word also returns it there for the next request.
`default_nettype none

module kv_request_line_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        is_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       req_type_o,
  output logic [2:0]       err_code_o,
  output logic [30:0]      ttl_value_o,
  output logic             close_session_o
);

  kvrlp_pkg::parse_state_t st_q, st_d, nx;
  kvrlp_pkg::result_t      res;
  kvrlp_pkg::result_t      out_q, skid_q;
  logic                    out_valid_q, skid_valid_q;
  logic                    in_acc;
  logic                    end_c;
  logic [7:0]              b;
  logic                    tok;
  logic                    redo;
  logic [1:0]              kind_c;
  logic [34:0]             ttl_mul;
  logic [2:0]              err_c;
  logic                    hit_get, hit_put, hit_exit;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;

  assign end_c = is_end_i || (ch_i == kvrlp_pkg::CH_NUL);
  assign b     = end_c ? kvrlp_pkg::CH_NUL : ch_i;
  assign tok   = (b > kvrlp_pkg::CH_SPACE) && (b < kvrlp_pkg::CH_DEL);

  // acc * 10 + digit as shift-add
  assign ttl_mul = ({4'd0, st_q.ttl_acc} << 3) + ({4'd0, st_q.ttl_acc} << 1)
                 + {31'd0, 4'(b - kvrlp_pkg::CH_D0)};

  assign hit_get  = st_q.type_match[0] &&
                    (st_q.type_len == kvrlp_pkg::type_length(kvrlp_pkg::REQ_GET));
  assign hit_put  = st_q.type_match[1] &&
                    (st_q.type_len == kvrlp_pkg::type_length(kvrlp_pkg::REQ_PUT));
  assign hit_exit = st_q.type_match[2] &&
                    (st_q.type_len == kvrlp_pkg::type_length(kvrlp_pkg::REQ_EXIT));

  always_comb begin
    nx     = st_q;
    kind_c = kvrlp_pkg::KIND_NONE;
    redo   = 1'b0;
    unique case (st_q.phase)
      kvrlp_pkg::PH_TYPE: begin
        if (tok) begin
          for (int i = 0; i < 3; i++) begin
            if (st_q.type_len >= kvrlp_pkg::type_length(2'(i)) ||
                kvrlp_pkg::type_char(2'(i), st_q.type_len[1:0]) != b) begin
              nx.type_match[i] = 1'b0;
            end
          end
          if (st_q.type_len != kvrlp_pkg::TYPE_LEN_MAX) nx.type_len = st_q.type_len + 3'd1;
        end else if (hit_get || hit_put || hit_exit) begin
          if (hit_get)      nx.kind_seen = kvrlp_pkg::REQ_GET;
          else if (hit_put) nx.kind_seen = kvrlp_pkg::REQ_PUT;
          else              nx.kind_seen = kvrlp_pkg::REQ_EXIT;
          nx.phase    = (!hit_get && !hit_put) ? kvrlp_pkg::PH_TAIL : kvrlp_pkg::PH_KEY_NAME;
          nx.name_pos = 3'd0;
          redo        = (b == kvrlp_pkg::CH_NUL) || (b == kvrlp_pkg::CH_FF);
        end else begin
          nx.error_seen = kvrlp_pkg::ERR_TYPE;
          nx.phase      = kvrlp_pkg::PH_DEAD;
        end
      end
      kvrlp_pkg::PH_KEY_NAME, kvrlp_pkg::PH_VALUE_NAME, kvrlp_pkg::PH_TTL_NAME: begin
        if (st_q.name_pos < kvrlp_pkg::name_length(st_q.phase)) begin
          if (b == kvrlp_pkg::name_char(st_q.phase, st_q.name_pos)) begin
            nx.name_pos = st_q.name_pos + 3'd1;
          end else begin
            nx.error_seen = kvrlp_pkg::ERR_NAME;
            nx.phase      = kvrlp_pkg::PH_DEAD;
          end
        end else if (b == kvrlp_pkg::CH_EQ) begin
          nx.phase    = kvrlp_pkg::phase_e'(st_q.phase + 4'd1);
          nx.name_pos = 3'd0;
        end else begin
          nx.error_seen = kvrlp_pkg::ERR_DELIM;
          nx.phase      = kvrlp_pkg::PH_DEAD;
        end
      end
      kvrlp_pkg::PH_KEY_VAL, kvrlp_pkg::PH_VALUE_VAL, kvrlp_pkg::PH_TTL_VAL: begin
        if (tok) begin
          if (st_q.phase == kvrlp_pkg::PH_KEY_VAL) begin
            kind_c = kvrlp_pkg::KIND_KEY;
          end else if (st_q.phase == kvrlp_pkg::PH_VALUE_VAL) begin
            kind_c = kvrlp_pkg::KIND_VALUE;
          end else if (b >= kvrlp_pkg::CH_D0 && b <= kvrlp_pkg::CH_D9) begin
            nx.ttl_acc = (ttl_mul > {4'd0, kvrlp_pkg::TTL_MAX}) ? kvrlp_pkg::TTL_MAX
                                                               : ttl_mul[30:0];
          end else begin
            nx.ttl_bad = 1'b1;
          end
        end else begin
          if (st_q.phase == kvrlp_pkg::PH_KEY_VAL) begin
            nx.phase = (st_q.kind_seen == kvrlp_pkg::REQ_PUT) ? kvrlp_pkg::PH_VALUE_NAME
                                                              : kvrlp_pkg::PH_TAIL;
          end else if (st_q.phase == kvrlp_pkg::PH_VALUE_VAL) begin
            nx.phase = kvrlp_pkg::PH_TTL_NAME;
          end else begin
            nx.phase = kvrlp_pkg::PH_TAIL;
          end
          nx.name_pos = 3'd0;
          redo        = (b == kvrlp_pkg::CH_NUL) || (b == kvrlp_pkg::CH_FF);
        end
      end
      kvrlp_pkg::PH_TAIL: begin
        if (b != kvrlp_pkg::CH_NUL) begin
          nx.error_seen = kvrlp_pkg::ERR_EXTRA;
          nx.phase      = kvrlp_pkg::PH_DEAD;
        end
      end
      default: begin
      end
    endcase

    // a kept delimiter (zero or 0xff) is seen again: in a name it can never
    // match, in the tail only zero is allowed
    if (redo) begin
      if (nx.phase == kvrlp_pkg::PH_TAIL) begin
        if (b != kvrlp_pkg::CH_NUL) begin
          nx.error_seen = kvrlp_pkg::ERR_EXTRA;
          nx.phase      = kvrlp_pkg::PH_DEAD;
        end
      end else begin
        nx.error_seen = kvrlp_pkg::ERR_NAME;
        nx.phase      = kvrlp_pkg::PH_DEAD;
      end
    end
  end

  always_comb begin
    err_c = nx.error_seen;
    if (nx.error_seen == kvrlp_pkg::ERR_OK && nx.kind_seen == kvrlp_pkg::REQ_PUT &&
        nx.ttl_bad) begin
      err_c = kvrlp_pkg::ERR_TTL;
    end
    res = '0;
    if (end_c) begin
      res.out_kind      = kvrlp_pkg::KIND_STATUS;
      res.req_type      = (nx.error_seen == kvrlp_pkg::ERR_TYPE) ? kvrlp_pkg::REQ_GET
                                                                 : nx.kind_seen;
      res.err_code      = err_c;
      res.ttl_value     = (err_c == kvrlp_pkg::ERR_OK && nx.kind_seen == kvrlp_pkg::REQ_PUT)
                          ? nx.ttl_acc : 31'd0;
      res.close_session = (err_c == kvrlp_pkg::ERR_OK && nx.kind_seen == kvrlp_pkg::REQ_EXIT);
      st_d              = kvrlp_pkg::ST_RESET;
    end else begin
      res.out_kind = kind_c;
      res.out_byte = (kind_c == kvrlp_pkg::KIND_KEY || kind_c == kvrlp_pkg::KIND_VALUE)
                     ? b : kvrlp_pkg::CH_NUL;
      st_d         = nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= kvrlp_pkg::ST_RESET;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = out_q.out_kind;
  assign out_byte_o      = out_q.out_byte;
  assign req_type_o      = out_q.req_type;
  assign err_code_o      = out_q.err_code;
  assign ttl_value_o     = out_q.ttl_value;
  assign close_session_o = out_q.close_session;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held while output register empty");

  a_end_resets_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_c) |=> (st_q == kvrlp_pkg::ST_RESET))
    else $error("parser state not back at start after end word");

  a_dead_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == kvrlp_pkg::PH_DEAD) |-> (st_q.error_seen != kvrlp_pkg::ERR_OK))
    else $error("parser stopped without an error code");

  a_stream_byte_is_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.out_kind == kvrlp_pkg::KIND_KEY ||
                     out_q.out_kind == kvrlp_pkg::KIND_VALUE))
    |-> (out_q.out_byte > kvrlp_pkg::CH_SPACE && out_q.out_byte < kvrlp_pkg::CH_DEL))
    else $error("streamed key or value byte is not a token byte");
`endif

endmodule

`default_nettype wire

/* verif/kv_request_line_parser_tb.sv */
`default_nettype none

module kv_request_line_parser_tb;
  import kvrlp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned CALM_FROM    = 1200;
  localparam int unsigned CALM_TO      = 2000;
  localparam int unsigned RANDOM_WORDS = 1240;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [7:0] ch;
    logic       is_end;
    bit         hold;
  } in_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  ch = 8'd0;
  logic        is_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [1:0]  req_type;
  logic [2:0]  err_code;
  logic [30:0] ttl_value;
  logic        close_session;

  int unsigned cycle = 0;
  int unsigned fails = 0;
  int unsigned n_words = 0;
  bit          hold_next = 1'b0;

  in_word_t    in_words_q[$];
  in_word_t    next_w;
  result_t     parse_results_q[$];
  result_t     head;

  // own copy of the parser state
  phase_e      ph;
  logic [2:0]  name_idx;
  logic [2:0]  tmatch;
  logic [2:0]  tlen;
  logic [1:0]  kind_seen;
  logic [2:0]  err_seen;
  logic [30:0] ttl_acc;
  logic        ttl_bad;
  logic [1:0]  step_kind;

  kv_request_line_parser dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .ch_i           (ch),
    .is_end_i       (is_end),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_kind_o     (out_kind),
    .out_byte_o     (out_byte),
    .req_type_o     (req_type),
    .err_code_o     (err_code),
    .ttl_value_o    (ttl_value),
    .close_session_o(close_session)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_parse();
    ph = PH_TYPE;
    name_idx = 3'd0;
    tmatch = 3'b111;
    tlen = 3'd0;
    kind_seen = REQ_GET;
    err_seen = ERR_OK;
    ttl_acc = 31'd0;
    ttl_bad = 1'b0;
  endfunction

  function automatic void fail_with(input logic [2:0] code);
    err_seen = code;
    ph = PH_DEAD;
  endfunction

  function automatic bit is_token(input logic [7:0] b);
    return b > CH_SPACE && b < CH_DEL;
  endfunction

  function automatic string type_text(input int k);
    string t;
    case (k)
      0:       t = "GET";
      1:       t = "PUT";
      default: t = "EXIT";
    endcase
    return t;
  endfunction

  // one grammar step; returns 1 when the byte must be seen again
  function automatic bit parse_byte(input logic [7:0] b);
    int          i;
    int          hit;
    string       nm;
    bit          again;
    logic [63:0] wide;
    again = 1'b0;
    case (ph)
      PH_TYPE: begin
        if (is_token(b)) begin
          for (i = 0; i < 3; i++) begin
            nm = type_text(i);
            if (tlen >= nm.len() || nm[tlen[1:0]] != b) tmatch[i] = 1'b0;
          end
          if (tlen < TYPE_LEN_MAX) tlen = tlen + 3'd1;
        end else begin
          hit = 3;
          for (i = 2; i >= 0; i--) begin
            nm = type_text(i);
            if (tmatch[i] && tlen == nm.len()) hit = i;
          end
          if (hit == 3) begin
            fail_with(ERR_TYPE);
          end else begin
            kind_seen = 2'(hit);
            ph = (kind_seen == REQ_EXIT) ? PH_TAIL : PH_KEY_NAME;
            name_idx = 3'd0;
            again = (b == CH_NUL || b == CH_FF);
          end
        end
      end
      PH_KEY_NAME, PH_VALUE_NAME, PH_TTL_NAME: begin
        if (ph == PH_KEY_NAME) nm = "KEY";
        else if (ph == PH_VALUE_NAME) nm = "VALUE";
        else nm = "TTL";
        if (name_idx < nm.len()) begin
          if (b == nm[name_idx]) name_idx = name_idx + 3'd1;
          else fail_with(ERR_NAME);
        end else if (b == CH_EQ) begin
          ph = phase_e'(ph + 4'd1);
          name_idx = 3'd0;
        end else begin
          fail_with(ERR_DELIM);
        end
      end
      PH_KEY_VAL, PH_VALUE_VAL, PH_TTL_VAL: begin
        if (is_token(b)) begin
          if (ph == PH_KEY_VAL) begin
            step_kind = KIND_KEY;
          end else if (ph == PH_VALUE_VAL) begin
            step_kind = KIND_VALUE;
          end else if (b >= CH_D0 && b <= CH_D9) begin
            wide = {33'd0, ttl_acc} * 64'd10 + 64'(b - CH_D0);
            ttl_acc = (wide > 64'(TTL_MAX)) ? TTL_MAX : wide[30:0];
          end else begin
            ttl_bad = 1'b1;
          end
        end else begin
          if (ph == PH_KEY_VAL) ph = (kind_seen == REQ_PUT) ? PH_VALUE_NAME : PH_TAIL;
          else if (ph == PH_VALUE_VAL) ph = PH_TTL_NAME;
          else ph = PH_TAIL;
          name_idx = 3'd0;
          again = (b == CH_NUL || b == CH_FF);
        end
      end
      PH_TAIL: begin
        if (b != CH_NUL) fail_with(ERR_EXTRA);
      end
      default: ;
    endcase
    return again;
  endfunction

  function automatic void parse_step(input logic [7:0] c, input logic e);
    logic [7:0] b;
    logic       fin;
    bit         more;
    int         g;
    logic [2:0] err;
    result_t    r;
    fin = e || (c == CH_NUL);
    b = fin ? CH_NUL : c;
    step_kind = KIND_NONE;
    more = 1'b1;
    for (g = 0; g < 16 && more; g++) more = parse_byte(b);
    r = '0;
    r.out_kind = step_kind;
    if (step_kind == KIND_KEY || step_kind == KIND_VALUE) r.out_byte = b;
    if (fin) begin
      err = err_seen;
      // a bad ttl digit only shows when nothing else went wrong
      if (err == ERR_OK && kind_seen == REQ_PUT && ttl_bad) err = ERR_TTL;
      r.out_kind = KIND_STATUS;
      r.req_type = (err_seen == ERR_TYPE) ? REQ_GET : kind_seen;
      r.err_code = err;
      if (err == ERR_OK && kind_seen == REQ_PUT) r.ttl_value = ttl_acc;
      r.close_session = (err == ERR_OK && kind_seen == REQ_EXIT);
      clear_parse();
    end
    parse_results_q.push_back(r);
  endfunction

  function automatic bit idle_now();
    return !(cycle >= CALM_FROM && cycle < CALM_TO) && ($urandom_range(0, 99) < 28);
  endfunction

  function automatic void check_field(input string name, input logic [30:0] want,
                                      input logic [30:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  task automatic push_word(input logic [7:0] c, input logic e);
    in_words_q.push_back('{ch: c, is_end: e, hold: hold_next});
    hold_next = 1'b0;
    n_words++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_word(s[i], 1'b0);
  endtask

  task automatic push_end();
    if ($urandom_range(0, 1) != 0) push_word(8'($urandom_range(0, 255)), 1'b1);
    else push_word(CH_NUL, 1'b0);
  endtask

  task automatic push_tokens(input int n);
    int i;
    for (i = 0; i < n; i++) push_word(8'($urandom_range(33, 127)), 1'b0);
  endtask

  function automatic logic [7:0] rand_delim();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'($urandom_range(1, 32));
    if (r < 9) return 8'($urandom_range(128, 254));
    return CH_FF;
  endfunction

  task automatic push_request();
    int k;
    int n;
    int i;
    int r;
    k = $urandom_range(0, 2);
    push_text(type_text(k));
    if (k != 2) begin
      push_word(rand_delim(), 1'b0);
      push_text("KEY=");
      push_tokens($urandom_range(0, 6));
      if (k == 1) begin
        push_word(rand_delim(), 1'b0);
        push_text("VALUE=");
        push_tokens($urandom_range(0, 6));
        push_word(rand_delim(), 1'b0);
        push_text("TTL=");
        // long digit strings can drive the ttl into saturation
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6);
        for (i = 0; i < n; i++) push_word(8'(CH_D0 + $urandom_range(0, 9)), 1'b0);
        if ($urandom_range(0, 9) == 0) push_word(8'($urandom_range(33, 127)), 1'b0);
      end
    end
    r = $urandom_range(0, 9);
    if (r >= 6) push_word(rand_delim(), 1'b0);
    if (r == 9) push_tokens($urandom_range(1, 3));
    push_end();
  endtask

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) parse_step(ch, is_end);
      if (!in_valid || !in_stall) begin
        if (in_words_q.size() != 0 && !(in_words_q[0].hold && parse_results_q.size() != 0)
            && !idle_now()) begin
          next_w = in_words_q.pop_front();
          in_valid <= 1'b1;
          ch <= next_w.ch;
          is_end <= next_w.is_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (parse_results_q.size() == 0) begin
          $error("output word with nothing pending: kind %0d", out_kind);
          fails++;
        end else begin
          head = parse_results_q.pop_front();
          check_field("out_kind", 31'(head.out_kind), 31'(out_kind));
          check_field("out_byte", 31'(head.out_byte), 31'(out_byte));
          check_field("req_type", 31'(head.req_type), 31'(req_type));
          check_field("err_code", 31'(head.err_code), 31'(err_code));
          check_field("ttl_value", head.ttl_value, ttl_value);
          check_field("close_session", 31'(head.close_session), 31'(close_session));
        end
      end
      out_stall <= idle_now();
    end
  end

  initial begin
    int req;
    int start;
    int r;
    int i;
    clear_parse();

    push_text("EXIT");
    push_word(CH_FF, 1'b1);
    push_text("GET KEY=k");
    push_word(CH_NUL, 1'b0);
    push_text("PUT");
    push_word(CH_DEL, 1'b0);
    push_text("KEY=ab");
    push_word(8'h01, 1'b0);
    push_text("VALUE=~");
    push_word(8'h7F, 1'b0);
    push_word(CH_SPACE, 1'b0);
    push_text("TTL=99999999999");
    push_word(8'h41, 1'b1);
    // empty type token
    push_word(CH_NUL, 1'b1);
    push_text("GETX");
    push_end();
    // end inside a name, and where a name is due
    push_text("GET KE");
    push_end();
    push_text("GET ");
    push_end();
    // end where the equals sign is due
    push_text("GET KEY");
    push_end();
    push_text("EXIT x");
    push_end();
    push_text("EXIT");
    push_word(CH_FF, 1'b0);
    push_end();
    push_text("PUT KEY=a VALUE=b TTL=1x2");
    push_end();
    // extra symbols win over a bad ttl
    push_text("PUT KEY=a VALUE=b TTL=x y");
    push_end();
    push_text("PUT KEY= VALUE= TTL=");
    push_word(8'hFE, 1'b0);
    push_end();

    n_words = 0;
    req = 0;
    while (n_words < RANDOM_WORDS) begin
      if (req == 50 || req == 150) hold_next = 1'b1;
      start = in_words_q.size();
      r = $urandom_range(0, 99);
      if (r < 15) begin
        repeat ($urandom_range(1, 10)) push_word(8'($urandom_range(1, 255)), 1'b0);
        push_end();
      end else begin
        push_request();
        if (r < 30) begin
          // overwrite one word of the request, not its end word, with a random byte
          i = $urandom_range(start, in_words_q.size() - 2);
          in_words_q[i].ch = 8'($urandom_range(0, 255));
        end
      end
      req++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (in_words_q.size() != 0 || in_valid || parse_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (parse_results_q.size() != 0) begin
      $error("%0d output words never arrived", parse_results_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/kvrlp_pkg.sv
rtl/kv_request_line_parser.sv
verif/kv_request_line_parser_tb.sv
